// ----- design/parallelogram_fill_rasterizer_top_assert.svh -----
// assertion macros for the parallelogram fill rasterizer checker
// no dependencies
`ifndef PARALLELOGRAM_FILL_RASTERIZER_TOP_ASSERT_SVH
`define PARALLELOGRAM_FILL_RASTERIZER_TOP_ASSERT_SVH
`define PFR_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("pfr check failed");
`define PFR_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("pfr check failed");
`endif

// ----- design/pfr_pkg.sv -----
// shared types and constants for the parallelogram fill rasterizer
// no dependencies
package pfr_pkg;
    typedef enum logic [1:0] {
        OCT_SHALLOW_UP   = 2'd0,
        OCT_SHALLOW_DOWN = 2'd1,
        OCT_STEEP_RIGHT  = 2'd2,
        OCT_STEEP_LEFT   = 2'd3
    } t_octant;
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;
endpackage

// ----- design/pfr_front.sv -----
// front end: registers items, orders a and b along the major axis and picks the partner corner
// no dependencies
module pfr_front #(
    parameter int CW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_cx,
    input  logic signed [CW-1:0] i_cy,
    input  logic signed [CW-1:0] i_dx,
    input  logic signed [CW-1:0] i_dy,
    input  logic                 i_line_only,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic                 o_kind,
    output logic signed [CW-1:0] o_ax,
    output logic signed [CW-1:0] o_ay,
    output logic signed [CW-1:0] o_bx,
    output logic signed [CW-1:0] o_by,
    output logic signed [CW-1:0] o_px,
    output logic signed [CW-1:0] o_py,
    output logic                 o_line_only
);
    // queue of two entries between front and back
    logic                 r_k [2];
    logic                 r_l [2];
    logic signed [CW-1:0] r_c [2][6];
    logic                 r_wp, r_rp;
    logic [1:0]           r_cnt;
    logic signed [CW-1:0] w_ax, w_ay, w_bx, w_by;
    logic                 w_sw, w_push, w_pop;
    logic signed [CW:0]   w_ddx, w_ddy, w_adx, w_ady;

    // classify: decide whether a and b swap, pick partner
    always_comb begin
        w_ddx = {i_bx[CW-1], i_bx} - {i_ax[CW-1], i_ax};
        w_ddy = {i_by[CW-1], i_by} - {i_ay[CW-1], i_ay};
        w_adx = w_ddx[CW] ? -w_ddx : w_ddx;
        w_ady = w_ddy[CW] ? -w_ddy : w_ddy;
        if (w_ady <= w_adx) begin
            w_sw = i_ax > i_bx;
        end else begin
            w_sw = i_ay > i_by;
        end
        w_ax = w_sw ? i_bx : i_ax;
        w_ay = w_sw ? i_by : i_ay;
        w_bx = w_sw ? i_ax : i_bx;
        w_by = w_sw ? i_ay : i_by;
    end

    assign o_ready = (r_cnt != 2'd2);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_valid = (r_cnt != 2'd0);
    assign o_kind  = r_k[r_rp];
    assign o_line_only = r_l[r_rp];
    assign o_ax = r_c[r_rp][0];
    assign o_ay = r_c[r_rp][1];
    assign o_bx = r_c[r_rp][2];
    assign o_by = r_c[r_rp][3];
    assign o_px = r_c[r_rp][4];
    assign o_py = r_c[r_rp][5];

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end

    // queue payload
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_k[r_wp]    <= i_kind;
            r_l[r_wp]    <= i_line_only;
            r_c[r_wp][0] <= w_ax;
            r_c[r_wp][1] <= w_ay;
            r_c[r_wp][2] <= w_bx;
            r_c[r_wp][3] <= w_by;
            r_c[r_wp][4] <= w_sw ? i_cx : i_dx;
            r_c[r_wp][5] <= w_sw ? i_cy : i_dy;
        end
    end
endmodule

// ----- design/pfr_walk_init.sv -----
// bresenham setup: octant, increments and end from two points (unordered)
// uses pfr_pkg
module pfr_walk_init #(
    parameter int CW = 12
) (
    input  logic signed [CW-1:0] i_x1,
    input  logic signed [CW-1:0] i_y1,
    input  logic signed [CW-1:0] i_x2,
    input  logic signed [CW-1:0] i_y2,
    output logic signed [CW-1:0] o_x,
    output logic signed [CW-1:0] o_y,
    output logic signed [CW+3:0] o_err,
    output logic signed [CW-1:0] o_end,
    output logic signed [CW+3:0] o_s,
    output logic signed [CW+3:0] o_t,
    output pfr_pkg::t_octant     o_oct
);
    logic signed [CW+3:0] w_dx, w_dy, w_adx, w_ady;
    logic                 w_neg, w_sh, w_sw;

    // octant class, swap so the major axis rises, then increments
    always_comb begin
        w_dx  = (CW+4)'(i_x2) - (CW+4)'(i_x1);
        w_dy  = (CW+4)'(i_y2) - (CW+4)'(i_y1);
        w_neg = w_dx[CW+3] != w_dy[CW+3];
        w_adx = w_dx[CW+3] ? -w_dx : w_dx;
        w_ady = w_dy[CW+3] ? -w_dy : w_dy;
        w_sh  = w_ady <= w_adx;
        o_oct = w_sh ? (w_neg ? pfr_pkg::OCT_SHALLOW_DOWN : pfr_pkg::OCT_SHALLOW_UP)
                     : (w_neg ? pfr_pkg::OCT_STEEP_LEFT : pfr_pkg::OCT_STEEP_RIGHT);
        w_sw  = w_sh ? (i_x1 > i_x2) : (i_y1 > i_y2);
        if (w_sw) begin
            w_dx = -w_dx;
            w_dy = -w_dy;
        end
        o_x = w_sw ? i_x2 : i_x1;
        o_y = w_sw ? i_y2 : i_y1;
        unique case (o_oct)
            pfr_pkg::OCT_SHALLOW_UP: begin
                o_s = w_dy <<< 1; o_t = (w_dy <<< 1) - (w_dx <<< 1);
                o_err = (w_dy <<< 1) - w_dx; o_end = w_sw ? i_x1 : i_x2;
            end
            pfr_pkg::OCT_SHALLOW_DOWN: begin
                o_s = (w_dx <<< 1) + (w_dy <<< 1); o_t = w_dy <<< 1;
                o_err = (w_dy <<< 1) + w_dx; o_end = w_sw ? i_x1 : i_x2;
            end
            pfr_pkg::OCT_STEEP_RIGHT: begin
                o_s = w_dx <<< 1; o_t = (w_dx <<< 1) - (w_dy <<< 1);
                o_err = (w_dx <<< 1) - w_dy; o_end = w_sw ? i_y1 : i_y2;
            end
            default: begin
                o_s = (w_dx <<< 1) + (w_dy <<< 1); o_t = w_dx <<< 1;
                o_err = (w_dx <<< 1) + w_dy; o_end = w_sw ? i_y1 : i_y2;
            end
        endcase
    end
endmodule

// ----- design/pfr_back.sv -----
// back end: edge and span bresenham walkers, output register stage
// uses pfr_pkg, pfr_walk_init
module pfr_back #(
    parameter int CW = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_kind,
    input  logic signed [CW-1:0] i_ax,
    input  logic signed [CW-1:0] i_ay,
    input  logic signed [CW-1:0] i_bx,
    input  logic signed [CW-1:0] i_by,
    input  logic signed [CW-1:0] i_px,
    input  logic signed [CW-1:0] i_py,
    input  logic                 i_line_only,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [CW-1:0] o_pixel_x,
    output logic signed [CW-1:0] o_pixel_y,
    output logic                 o_last
);
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [CW+3:0] err;
        logic signed [CW-1:0] fin;
        logic signed [CW+3:0] s;
        logic signed [CW+3:0] t;
        pfr_pkg::t_octant     oct;
    } t_walk;

    t_walk                r_e, r_s, n_e, n_s, w_ei, w_si, w_en, w_sn;
    logic signed [CW-1:0] r_px, r_py, n_px, n_py;
    logic                 r_fill, r_act, n_fill, n_act;
    logic                 r_ov, r_last;
    logic signed [CW-1:0] r_ox, r_oy;
    logic                 w_acc, w_emit, w_edone, w_sdone, w_start;
    logic signed [CW-1:0] w_sx1, w_sy1, w_sx2, w_sy2, w_ex, w_ey, w_lx, w_ly;
    logic                 w_llast;

    // start setup for the edge
    pfr_walk_init #(.CW(CW)) u_einit (
        .i_x1(i_ax), .i_y1(i_ay), .i_x2(i_bx), .i_y2(i_by),
        .o_x(w_ei.x), .o_y(w_ei.y), .o_err(w_ei.err), .o_end(w_ei.fin),
        .o_s(w_ei.s), .o_t(w_ei.t), .o_oct(w_ei.oct)
    );

    // span setup shared by start and edge advance
    pfr_walk_init #(.CW(CW)) u_sinit (
        .i_x1(w_sx1), .i_y1(w_sy1), .i_x2(w_sx2), .i_y2(w_sy2),
        .o_x(w_si.x), .o_y(w_si.y), .o_err(w_si.err), .o_end(w_si.fin),
        .o_s(w_si.s), .o_t(w_si.t), .o_oct(w_si.oct)
    );

    function automatic t_walk f_next(input t_walk w);
        logic lo;
        lo = w.err[CW+3];
        f_next = w;
        unique case (w.oct)
            pfr_pkg::OCT_SHALLOW_UP: begin
                if (lo) f_next.err = w.err + w.s;
                else begin f_next.y = w.y + 1'b1; f_next.err = w.err + w.t; end
                f_next.x = w.x + 1'b1;
            end
            pfr_pkg::OCT_SHALLOW_DOWN: begin
                if (lo) begin f_next.y = w.y - 1'b1; f_next.err = w.err + w.s; end
                else f_next.err = w.err + w.t;
                f_next.x = w.x + 1'b1;
            end
            pfr_pkg::OCT_STEEP_RIGHT: begin
                if (lo) f_next.err = w.err + w.s;
                else begin f_next.x = w.x + 1'b1; f_next.err = w.err + w.t; end
                f_next.y = w.y + 1'b1;
            end
            default: begin
                if (lo) begin f_next.x = w.x - 1'b1; f_next.err = w.err + w.s; end
                else f_next.err = w.err + w.t;
                f_next.y = w.y + 1'b1;
            end
        endcase
    endfunction

    function automatic logic f_done(input t_walk w);
        f_done = ((w.oct == pfr_pkg::OCT_SHALLOW_UP || w.oct == pfr_pkg::OCT_SHALLOW_DOWN)
                  ? w.x : w.y) >= w.fin;
    endfunction

    // handshake and walker step
    assign o_ready = !r_ov || i_ready;
    assign w_acc   = i_valid && o_ready;
    assign w_start = w_acc && (i_kind == pfr_pkg::KIND_START);
    assign w_emit  = w_acc && (i_kind == pfr_pkg::KIND_STEP) && r_act;

    always_comb begin
        w_en    = f_next(r_e);
        w_sn    = f_next(r_s);
        w_edone = f_done(r_e);
        w_sdone = f_done(r_s);
        w_ex    = r_px + (w_en.x - r_e.x);
        w_ey    = r_py + (w_en.y - r_e.y);
        if (w_start) begin
            w_sx1 = w_ei.x; w_sy1 = w_ei.y; w_sx2 = i_px; w_sy2 = i_py;
        end else begin
            w_sx1 = w_en.x; w_sy1 = w_en.y; w_sx2 = w_ex; w_sy2 = w_ey;
        end
    end

    // next state
    always_comb begin
        n_e = r_e; n_s = r_s; n_px = r_px; n_py = r_py;
        n_fill = r_fill; n_act = r_act;
        w_lx = r_e.x; w_ly = r_e.y; w_llast = w_edone;
        if (w_start) begin
            n_e = w_ei; n_px = i_px; n_py = i_py;
            n_fill = !i_line_only; n_act = 1'b1;
            if (!i_line_only) n_s = w_si;
        end else if (w_emit) begin
            if (!r_fill) begin
                if (w_edone) n_act = 1'b0;
                else begin n_e = w_en; n_px = w_ex; n_py = w_ey; end
            end else begin
                w_lx = r_s.x; w_ly = r_s.y; w_llast = w_sdone && w_edone;
                if (!w_sdone) n_s = w_sn;
                else if (w_edone) n_act = 1'b0;
                else begin n_e = w_en; n_px = w_ex; n_py = w_ey; n_s = w_si; end
            end
        end
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e <= '0; r_s <= '0; r_px <= '0; r_py <= '0;
            r_fill <= 1'b0; r_act <= 1'b0; r_ov <= 1'b0;
        end else begin
            r_e <= n_e; r_s <= n_s; r_px <= n_px; r_py <= n_py;
            r_fill <= n_fill; r_act <= n_act;
            if (w_emit) r_ov <= 1'b1;
            else if (i_ready) r_ov <= 1'b0;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_ox <= w_lx; r_oy <= w_ly; r_last <= w_llast;
        end
    end

    assign o_valid   = r_ov;
    assign o_pixel_x = r_ox;
    assign o_pixel_y = r_oy;
    assign o_last    = r_last;
endmodule

// ----- design/parallelogram_fill_rasterizer_top.sv -----
// Parallelogram fill rasterizer. A start item (kind 0) loads edge A-B, corners C/D
// and the mode and gives no pixel; each step item (kind 1) then gives one pixel
// until the pixel marked last. Steps while idle are dropped. A two-entry queue
// parts the classifying front from the walker; the walker takes one item per cycle
// while the output is not held by i_ready, set by one Bresenham add and compare.
// Depends on pfr_pkg, pfr_front, pfr_back.
module parallelogram_fill_rasterizer_top #(
    parameter int COORD_WIDTH = 12
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic                          i_kind,
    input  logic signed [COORD_WIDTH-1:0] i_ax,
    input  logic signed [COORD_WIDTH-1:0] i_ay,
    input  logic signed [COORD_WIDTH-1:0] i_bx,
    input  logic signed [COORD_WIDTH-1:0] i_by,
    input  logic signed [COORD_WIDTH-1:0] i_cx,
    input  logic signed [COORD_WIDTH-1:0] i_cy,
    input  logic signed [COORD_WIDTH-1:0] i_dx_corner,
    input  logic signed [COORD_WIDTH-1:0] i_dy_corner,
    input  logic                          i_line_only,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [COORD_WIDTH-1:0] o_pixel_x,
    output logic signed [COORD_WIDTH-1:0] o_pixel_y,
    output logic                          o_last
);
    logic                          w_qv, w_qr, w_qk, w_ql;
    logic signed [COORD_WIDTH-1:0] w_ax, w_ay, w_bx, w_by, w_px, w_py;

    // front: classify and queue
    pfr_front #(.CW(COORD_WIDTH)) u_front (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind,
        .i_ax, .i_ay, .i_bx, .i_by, .i_cx, .i_cy,
        .i_dx(i_dx_corner), .i_dy(i_dy_corner), .i_line_only,
        .o_valid(w_qv), .i_ready(w_qr), .o_kind(w_qk),
        .o_ax(w_ax), .o_ay(w_ay), .o_bx(w_bx), .o_by(w_by),
        .o_px(w_px), .o_py(w_py), .o_line_only(w_ql)
    );

    // back: walk and emit
    pfr_back #(.CW(COORD_WIDTH)) u_back (
        .i_clk, .i_rst_n, .i_valid(w_qv), .o_ready(w_qr), .i_kind(w_qk),
        .i_ax(w_ax), .i_ay(w_ay), .i_bx(w_bx), .i_by(w_by),
        .i_px(w_px), .i_py(w_py), .i_line_only(w_ql),
        .o_valid, .i_ready, .o_pixel_x, .o_pixel_y, .o_last
    );
endmodule

// ----- design/pfr_checker.sv -----
// port checker for the rasterizer top level, bound to it
// uses parallelogram_fill_rasterizer_top_assert.svh
`include "parallelogram_fill_rasterizer_top_assert.svh"
module pfr_checker #(
    parameter int CW = 12
) (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input logic          i_kind,
    input logic          o_valid,
    input logic          i_ready,
    input logic [CW-1:0] o_pixel_x,
    input logic          o_last
);
    // a held result keeps its pixel x and flag
    `PFR_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && !i_ready, $stable({o_pixel_x, o_last}))
    // a held result stays valid
    `PFR_ASSERT_NEXT(a_stay, i_clk, i_rst_n, o_valid && !i_ready, o_valid)
    // a waiting request stays offered with the same kind
    `PFR_ASSERT_NEXT(a_in_hold, i_clk, i_rst_n, i_valid && !o_ready, i_valid && $stable(i_kind))
    // nothing comes out right after reset
    `PFR_ASSERT_IMPL(a_rst, i_clk, i_rst_n, $rose(i_rst_n), !o_valid)
endmodule

bind parallelogram_fill_rasterizer_top pfr_checker #(.CW(COORD_WIDTH)) u_chk (
    .i_clk, .i_rst_n, .i_valid, .o_ready, .i_kind,
    .o_valid, .i_ready, .o_pixel_x, .o_last
);
